@@ design/hcsg_pkg.sv @@
package hcsg_pkg;

	// Sequence length and list storage
	localparam int HopCountDefault = 23;
	localparam int HopCountMax     = 23;

	// Generator and channel mapping
	localparam logic [31:0] LcgMul    = 32'h0019_660D;
	localparam logic [31:0] LcgAdd    = 32'h3C6E_F35F;
	localparam int          ChanSpan  = 'h49;
	localparam logic [6:0]  ChanBase  = 7'd3;
	// floor(2^30 / 73): quotient estimate is exact or one low for 24-bit inputs
	localparam int          RecipShift = 30;
	localparam logic [23:0] Recip      = 24'((64'd1 << RecipShift) / ChanSpan);

	// Band edges and capacities
	localparam logic [6:0] LowTop  = 7'd27;
	localparam logic [6:0] MidTop  = 7'd51;
	localparam logic [3:0] LowCap  = 4'd8;
	localparam logic [3:0] MidCap  = 4'd7;
	localparam logic [3:0] HighCap = 4'd8;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_LCG,
		OP_QUOT,
		OP_CAND,
		OP_SCAN,
		OP_ACCEPT,
		OP_OUT_INIT,
		OP_OUT_LOAD
	} dp_op_t;

	// Jump conditions
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_REJECT,
		C_SCAN_DONE,
		C_MATCH,
		C_MORE_ACC,
		C_OUT_BUSY,
		C_MORE_OUT
	} cond_t;

	typedef logic [3:0] pc_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		pc_t    target;
	} ctl_word_t;

	// Program step addresses
	localparam pc_t StIdle     = 4'd0;
	localparam pc_t StStep     = 4'd1;
	localparam pc_t StQuot     = 4'd2;
	localparam pc_t StCand     = 4'd3;
	localparam pc_t StTest     = 4'd4;
	localparam pc_t StScanChk  = 4'd5;
	localparam pc_t StScanRd   = 4'd6;
	localparam pc_t StScanCmp  = 4'd7;
	localparam pc_t StScanLoop = 4'd8;
	localparam pc_t StAccept   = 4'd9;
	localparam pc_t StOutInit  = 4'd10;
	localparam pc_t StOutWait  = 4'd11;
	localparam pc_t StOutLoad  = 4'd12;
	localparam pc_t StDone     = 4'd13;

	// Control store
	function automatic ctl_word_t rom_word(input pc_t pc);
		ctl_word_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, target: StIdle};
		case (pc)
			StIdle:     w = '{op: OP_LOAD,     cond: C_NO_INPUT,  target: StIdle};
			StStep:     w = '{op: OP_LCG,      cond: C_NEXT,      target: StIdle};
			StQuot:     w = '{op: OP_QUOT,     cond: C_NEXT,      target: StIdle};
			StCand:     w = '{op: OP_CAND,     cond: C_NEXT,      target: StIdle};
			StTest:     w = '{op: OP_NONE,     cond: C_REJECT,    target: StStep};
			StScanChk:  w = '{op: OP_NONE,     cond: C_SCAN_DONE, target: StAccept};
			StScanRd:   w = '{op: OP_SCAN,     cond: C_NEXT,      target: StIdle};
			StScanCmp:  w = '{op: OP_NONE,     cond: C_MATCH,     target: StStep};
			StScanLoop: w = '{op: OP_NONE,     cond: C_ALWAYS,    target: StScanChk};
			StAccept:   w = '{op: OP_ACCEPT,   cond: C_MORE_ACC,  target: StStep};
			StOutInit:  w = '{op: OP_OUT_INIT, cond: C_NEXT,      target: StIdle};
			StOutWait:  w = '{op: OP_NONE,     cond: C_OUT_BUSY,  target: StOutWait};
			StOutLoad:  w = '{op: OP_OUT_LOAD, cond: C_MORE_OUT,  target: StOutWait};
			StDone:     w = '{op: OP_NONE,     cond: C_ALWAYS,    target: StIdle};
			default:    w = '{op: OP_NONE,     cond: C_ALWAYS,    target: StIdle};
		endcase
		return w;
	endfunction

endpackage

@@ design/hop_channel_sequence_gen.sv @@
// Hop sequence generator. One input transfer (radio_id, model_number) yields
// HOP_COUNT output transfers: the accepted channels in order, each with its
// slot number, the final one flagged by last_channel. A small control store
// sequences a shared datapath: one 32-bit generator multiplier, one
// reciprocal multiply for the mod-73 reduction, and a single-port scan over
// the list of channels already chosen. Each generator draw steps the
// generator, registers the quotient, then registers the candidate; a
// candidate that passes the parity and band checks then scans the list one
// stored channel at a time, and an accept appends it to the list. The scans
// grow with each accept, and rejected draws (wrong parity, full band, or a
// duplicate found part way through the scan) add more. Results then drain
// in order, each held in the output register while out_ready is low.
// A new input is taken only once the last result sits in the output
// register.
module hop_channel_sequence_gen #(
	parameter int HOP_COUNT = hcsg_pkg::HopCountDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] radio_id,
	input  logic [7:0]  model_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  hop_channel,
	output logic [4:0]  hop_slot,
	output logic        last_channel
);

	localparam int CNT_W = $clog2(HOP_COUNT + 1);
	localparam int AW    = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(HOP_COUNT - 1);
	localparam int RecipShiftHi = hcsg_pkg::RecipShift + 17;

	// Sequencer
	hcsg_pkg::pc_t       pc_q;
	hcsg_pkg::ctl_word_t ctl;
	logic                jump;

	// Datapath registers
	logic [31:0]      lcg_q;
	logic [31:0]      seed_q;
	logic [17:0]      quot_q;
	logic [6:0]       cand_q;
	logic [CNT_W-1:0] count_q;   // channels accepted so far
	logic [CNT_W-1:0] idx_q;     // scan / drain index
	logic [3:0]       low_cnt_q;
	logic [3:0]       mid_cnt_q;
	logic [3:0]       high_cnt_q;

	// Chosen list: one write port, one registered read port at idx_q
	logic [6:0] list_mem [HOP_COUNT];
	logic [6:0] rd_q;

	// Output register
	logic       out_valid_q;
	logic [6:0] chan_q;
	logic [4:0] slot_q;
	logic       last_q;

	// Combinational datapath
	logic [8:0]  id_sum;
	logic [31:0] seed_new;
	logic [47:0] recip_prod;
	logic [24:0] rem_raw;
	logic [6:0]  rem_fix;
	logic [6:0]  cand_new;
	logic        band_full;
	logic        same_parity;
	logic        in_low;
	logic        in_mid;

	assign ctl = hcsg_pkg::rom_word(pc_q);

	assign id_sum   = {1'b0, radio_id[7:0]} + {1'b0, model_number};
	assign seed_new = ~({radio_id[31:8], 8'h00} | {23'd0, id_sum});

	// v / 73 estimate on the upper 24 generator bits
	assign recip_prod = {24'd0, lcg_q[31:8]} * {24'd0, hcsg_pkg::Recip};
	// v - q*73 lands in [0, 146): one conditional subtract finishes it
	assign rem_raw = {1'b0, lcg_q[31:8]} - (25'(quot_q) * 25'(hcsg_pkg::ChanSpan));
	assign rem_fix = (rem_raw >= 25'(hcsg_pkg::ChanSpan))
		? 7'(rem_raw - 25'(hcsg_pkg::ChanSpan)) : rem_raw[6:0];
	assign cand_new = rem_fix + hcsg_pkg::ChanBase;

	assign in_low      = (cand_q <= hcsg_pkg::LowTop);
	assign in_mid      = !in_low && (cand_q <= hcsg_pkg::MidTop);
	assign same_parity = (cand_q[0] == seed_q[0]);
	always_comb begin
		if (in_low) begin
			band_full = (low_cnt_q >= hcsg_pkg::LowCap);
		end else if (in_mid) begin
			band_full = (mid_cnt_q >= hcsg_pkg::MidCap);
		end else begin
			band_full = (high_cnt_q >= hcsg_pkg::HighCap);
		end
	end

	// Jump condition select
	always_comb begin
		case (ctl.cond)
			hcsg_pkg::C_NEXT:      jump = 1'b0;
			hcsg_pkg::C_ALWAYS:    jump = 1'b1;
			hcsg_pkg::C_NO_INPUT:  jump = !in_valid;
			hcsg_pkg::C_REJECT:    jump = same_parity || band_full;
			hcsg_pkg::C_SCAN_DONE: jump = (idx_q == count_q);
			hcsg_pkg::C_MATCH:     jump = (rd_q == cand_q);
			hcsg_pkg::C_MORE_ACC:  jump = (count_q != LAST_IDX);
			hcsg_pkg::C_OUT_BUSY:  jump = out_valid_q && !out_ready;
			hcsg_pkg::C_MORE_OUT:  jump = (idx_q != LAST_IDX);
			default:               jump = 1'b1;
		endcase
	end

	assign in_ready = (ctl.op == hcsg_pkg::OP_LOAD);

	// Step counter and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= hcsg_pkg::StIdle;
			lcg_q       <= '0;
			seed_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			low_cnt_q   <= '0;
			mid_cnt_q   <= '0;
			high_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= jump ? ctl.target : hcsg_pkg::pc_t'(pc_q + 4'd1);

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (ctl.op)
				hcsg_pkg::OP_LOAD: begin
					if (in_valid) begin
						seed_q     <= seed_new;
						lcg_q      <= seed_new;
						count_q    <= '0;
						low_cnt_q  <= '0;
						mid_cnt_q  <= '0;
						high_cnt_q <= '0;
					end
				end
				hcsg_pkg::OP_LCG: begin
					lcg_q <= lcg_q * hcsg_pkg::LcgMul + hcsg_pkg::LcgAdd;
				end
				hcsg_pkg::OP_CAND: begin
					idx_q <= '0;
				end
				hcsg_pkg::OP_SCAN: begin
					idx_q <= idx_q + CNT_W'(1);
				end
				hcsg_pkg::OP_ACCEPT: begin
					count_q <= count_q + CNT_W'(1);
					if (in_low) begin
						low_cnt_q <= low_cnt_q + 4'd1;
					end else if (in_mid) begin
						mid_cnt_q <= mid_cnt_q + 4'd1;
					end else begin
						high_cnt_q <= high_cnt_q + 4'd1;
					end
				end
				hcsg_pkg::OP_OUT_INIT: begin
					idx_q <= '0;
				end
				hcsg_pkg::OP_OUT_LOAD: begin
					out_valid_q <= 1'b1;
					idx_q       <= idx_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (ctl.op == hcsg_pkg::OP_QUOT) begin
			quot_q <= recip_prod[RecipShiftHi:hcsg_pkg::RecipShift];
		end
		if (ctl.op == hcsg_pkg::OP_CAND) begin
			cand_q <= cand_new;
		end
		if (ctl.op == hcsg_pkg::OP_OUT_LOAD) begin
			chan_q <= rd_q;
			slot_q <= 5'(idx_q);
			last_q <= (idx_q == LAST_IDX);
		end
	end

	// Chosen list memory
	always_ff @(posedge clk) begin
		if (ctl.op == hcsg_pkg::OP_ACCEPT) begin
			list_mem[count_q[AW-1:0]] <= cand_q;
		end
		rd_q <= list_mem[idx_q[AW-1:0]];
	end

	assign out_valid    = out_valid_q;
	assign hop_channel  = chan_q;
	assign hop_slot     = slot_q;
	assign last_channel = last_q;

endmodule
